### design/mlfq_pkg.sv
package mlfq_pkg;

  localparam int MAX_PROCS = 32;
  localparam int IDX_W = $clog2(MAX_PROCS);
  localparam int ID_W = 16;
  localparam int TIME_W = 32;
  localparam int SLICE_W = 16;
  localparam int LVL_W = 2;
  localparam int ST_W = 2;
  localparam int DCNT_W = $clog2(TIME_W);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_PROCS - 1);
  localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(TIME_W - 1);
  localparam logic [SLICE_W-1:0] SLICE_RESET = SLICE_W'(10);

  localparam logic [ST_W-1:0] ST_UPDATED = 2'd0;
  localparam logic [ST_W-1:0] ST_INSERTED = 2'd1;
  localparam logic [ST_W-1:0] ST_DROPPED = 2'd2;
  localparam logic [ST_W-1:0] ST_LISTING = 2'd3;
  localparam logic [LVL_W-1:0] TOP_LEVEL = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RFIN,
    S_DIV,
    S_LIST
  } state_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_UPD,
    EM_NEW,
    EM_LIST,
    EM_EMPTY
  } emit_t;

  typedef struct packed {
    logic  load;
    logic  prune;
    logic  scan;
    logic  idx_inc;
    logic  div_step;
    emit_t emit;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic idx_last;
    logic div_last;
    logic used_cur;
    logic any_used;
    logic last_used;
    logic out_free;
  } stat_t;

endpackage

### design/mlfq_priority_table.sv
// report word: table search one slot per cycle, then the result is registered
// snapshot word: bit-serial now_time mod slice_length, then one slot per cycle
// listing sweep, held at a used slot while output is full; one word in work at a time
// results leave through a single output register, so the next word is taken while
// the last result still waits
// reset: synchronous active low, clears the table, seen marks, output and slice_length to 10
module mlfq_priority_table (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [mlfq_pkg::SLICE_W-1:0]       cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_mode,
  input  logic [mlfq_pkg::ID_W-1:0]          in_proc_id,
  input  logic [mlfq_pkg::TIME_W-1:0]        in_run_time,
  input  logic [mlfq_pkg::TIME_W-1:0]        in_now_time,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mlfq_pkg::ST_W-1:0]          out_status,
  output logic [mlfq_pkg::ID_W-1:0]          out_id,
  output logic [mlfq_pkg::LVL_W-1:0]         out_level,
  output logic                               out_entry_valid,
  output logic                               out_last
);

  mlfq_pkg::cmd_t  cmd;
  mlfq_pkg::stat_t st;

  mlfq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  mlfq_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_proc_id      (in_proc_id),
    .in_run_time     (in_run_time),
    .in_now_time     (in_now_time),
    .cmd             (cmd),
    .st              (st),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_id          (out_id),
    .out_level       (out_level),
    .out_entry_valid (out_entry_valid),
    .out_last        (out_last)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("word accepted while previous word still in work");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_level != 2'd3))
    else $error("priority level out of range");

  a_invalid_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_entry_valid) |-> out_last)
    else $error("result without entry not marked last");

  a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != mlfq_pkg::ST_LISTING) |-> out_last)
    else $error("report result not marked last");
`endif

endmodule

### design/mlfq_ctrl.sv
module mlfq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_mode,
  output logic           in_stall,
  input  mlfq_pkg::stat_t st,
  output mlfq_pkg::cmd_t  cmd
);

  mlfq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mlfq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.emit = mlfq_pkg::EM_NONE;
    in_stall = 1'b1;
    case (state_r)
      mlfq_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.prune = in_mode;
          state_nxt = in_mode ? mlfq_pkg::S_DIV : mlfq_pkg::S_SCAN;
        end
      end
      mlfq_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.hit) begin
          if (st.out_free) begin
            cmd.emit = mlfq_pkg::EM_UPD;
            state_nxt = mlfq_pkg::S_IDLE;
          end
        end else if (st.idx_last) begin
          state_nxt = mlfq_pkg::S_RFIN;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      mlfq_pkg::S_RFIN: begin
        if (st.out_free) begin
          cmd.emit = mlfq_pkg::EM_NEW;
          state_nxt = mlfq_pkg::S_IDLE;
        end
      end
      mlfq_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_nxt = mlfq_pkg::S_LIST;
        end
      end
      mlfq_pkg::S_LIST: begin
        if (!st.any_used) begin
          if (st.out_free) begin
            cmd.emit = mlfq_pkg::EM_EMPTY;
            state_nxt = mlfq_pkg::S_IDLE;
          end
        end else if (st.used_cur) begin
          if (st.out_free) begin
            cmd.emit = mlfq_pkg::EM_LIST;
            if (st.last_used) begin
              state_nxt = mlfq_pkg::S_IDLE;
            end else begin
              cmd.idx_inc = 1'b1;
            end
          end
        end else if (st.idx_last) begin
          state_nxt = mlfq_pkg::S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      default: begin
        state_nxt = mlfq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### design/mlfq_dp.sv
module mlfq_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [mlfq_pkg::SLICE_W-1:0]      cfg_wr_data,
  input  logic [mlfq_pkg::ID_W-1:0]         in_proc_id,
  input  logic [mlfq_pkg::TIME_W-1:0]       in_run_time,
  input  logic [mlfq_pkg::TIME_W-1:0]       in_now_time,
  input  mlfq_pkg::cmd_t                    cmd,
  output mlfq_pkg::stat_t                   st,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mlfq_pkg::ST_W-1:0]         out_status,
  output logic [mlfq_pkg::ID_W-1:0]         out_id,
  output logic [mlfq_pkg::LVL_W-1:0]        out_level,
  output logic                              out_entry_valid,
  output logic                              out_last
);

  logic [mlfq_pkg::SLICE_W-1:0] slice_r;
  logic [mlfq_pkg::ID_W-1:0]    pid_r;
  logic [mlfq_pkg::TIME_W-1:0]  run_r;
  logic [mlfq_pkg::TIME_W-1:0]  now_r;
  logic [mlfq_pkg::SLICE_W:0]   rem_r;
  logic [mlfq_pkg::DCNT_W-1:0]  dcnt_r;
  logic [mlfq_pkg::IDX_W-1:0]   idx_r;
  logic [mlfq_pkg::IDX_W-1:0]   free_r;
  logic                         free_vld_r;
  logic [mlfq_pkg::MAX_PROCS-1:0] used_r;
  logic [mlfq_pkg::MAX_PROCS-1:0] seen_r;
  logic [mlfq_pkg::ID_W-1:0]    id_r    [mlfq_pkg::MAX_PROCS];
  logic [mlfq_pkg::TIME_W-1:0]  srun_r  [mlfq_pkg::MAX_PROCS];
  logic [mlfq_pkg::TIME_W-1:0]  start_r [mlfq_pkg::MAX_PROCS];
  logic [mlfq_pkg::LVL_W-1:0]   lvl_r   [mlfq_pkg::MAX_PROCS];

  logic                         ov_r;
  logic [mlfq_pkg::ST_W-1:0]    ost_r;
  logic [mlfq_pkg::ID_W-1:0]    oid_r;
  logic [mlfq_pkg::LVL_W-1:0]   olvl_r;
  logic                         oev_r;
  logic                         olast_r;

  logic [mlfq_pkg::SLICE_W:0]   rem_sh;
  logic [mlfq_pkg::SLICE_W:0]   rem_nxt;
  logic [mlfq_pkg::TIME_W-1:0]  cur_run;
  logic [mlfq_pkg::TIME_W-1:0]  cur_start;
  logic [mlfq_pkg::TIME_W-1:0]  run_diff;
  logic [mlfq_pkg::LVL_W-1:0]   cur_lvl;
  logic [mlfq_pkg::LVL_W-1:0]   new_lvl;
  logic                         demote;
  logic                         boost;
  logic [mlfq_pkg::MAX_PROCS-1:0] used_above;
  logic                         out_free;

  assign cur_run   = srun_r[idx_r];
  assign cur_start = start_r[idx_r];
  assign cur_lvl   = lvl_r[idx_r];
  assign run_diff  = cur_run - cur_start;
  assign demote    = (cur_run >= cur_start) &&
                     (run_diff >= {{(mlfq_pkg::TIME_W-mlfq_pkg::SLICE_W){1'b0}}, slice_r});
  assign boost     = (slice_r != '0) && (rem_r == '0);

  always_comb begin
    new_lvl = cur_lvl;
    if (demote && cur_lvl != '0) begin
      new_lvl = cur_lvl - 2'd1;
    end
    if (boost) begin
      new_lvl = mlfq_pkg::TOP_LEVEL;
    end
  end

  assign rem_sh  = {rem_r[mlfq_pkg::SLICE_W-1:0], now_r[mlfq_pkg::TIME_W-1]};
  assign rem_nxt = (rem_sh >= {1'b0, slice_r}) ? (rem_sh - {1'b0, slice_r}) : rem_sh;

  assign used_above = (used_r >> idx_r) >> 1;
  assign out_free   = !ov_r || !out_stall;

  always_comb begin
    st.hit       = used_r[idx_r] && (id_r[idx_r] == pid_r);
    st.idx_last  = (idx_r == mlfq_pkg::IDX_LAST);
    st.div_last  = (dcnt_r == mlfq_pkg::DIV_LAST);
    st.used_cur  = used_r[idx_r];
    st.any_used  = |used_r;
    st.last_used = (used_above == '0);
    st.out_free  = out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_r <= mlfq_pkg::SLICE_RESET;
      used_r  <= '0;
      seen_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        slice_r <= cfg_wr_data;
      end
      ov_r <= (ov_r && out_stall) || (cmd.emit != mlfq_pkg::EM_NONE);
      if (cmd.prune) begin
        used_r <= used_r & seen_r;
        seen_r <= '0;
      end
      case (cmd.emit)
        mlfq_pkg::EM_UPD: begin
          seen_r[idx_r] <= 1'b1;
        end
        mlfq_pkg::EM_NEW: begin
          if (free_vld_r) begin
            used_r[free_r] <= 1'b1;
            seen_r[free_r] <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pid_r      <= in_proc_id;
      run_r      <= in_run_time;
      now_r      <= in_now_time;
      rem_r      <= '0;
      dcnt_r     <= '0;
      idx_r      <= '0;
      free_vld_r <= 1'b0;
    end
    if (cmd.div_step) begin
      rem_r  <= rem_nxt;
      now_r  <= {now_r[mlfq_pkg::TIME_W-2:0], 1'b0};
      dcnt_r <= dcnt_r + 1'b1;
    end
    if (cmd.scan && !used_r[idx_r] && !free_vld_r) begin
      free_r     <= idx_r;
      free_vld_r <= 1'b1;
    end
    if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
    case (cmd.emit)
      mlfq_pkg::EM_UPD: begin
        srun_r[idx_r] <= run_r;
        ost_r   <= mlfq_pkg::ST_UPDATED;
        oid_r   <= pid_r;
        olvl_r  <= cur_lvl;
        oev_r   <= 1'b1;
        olast_r <= 1'b1;
      end
      mlfq_pkg::EM_NEW: begin
        oid_r   <= pid_r;
        olast_r <= 1'b1;
        if (free_vld_r) begin
          id_r[free_r]    <= pid_r;
          srun_r[free_r]  <= run_r;
          start_r[free_r] <= '0;
          lvl_r[free_r]   <= mlfq_pkg::TOP_LEVEL;
          ost_r  <= mlfq_pkg::ST_INSERTED;
          olvl_r <= mlfq_pkg::TOP_LEVEL;
          oev_r  <= 1'b1;
        end else begin
          ost_r  <= mlfq_pkg::ST_DROPPED;
          olvl_r <= '0;
          oev_r  <= 1'b0;
        end
      end
      mlfq_pkg::EM_LIST: begin
        lvl_r[idx_r] <= new_lvl;
        if (demote) begin
          start_r[idx_r] <= cur_run;
        end
        ost_r   <= mlfq_pkg::ST_LISTING;
        oid_r   <= id_r[idx_r];
        olvl_r  <= new_lvl;
        oev_r   <= 1'b1;
        olast_r <= (used_above == '0);
      end
      mlfq_pkg::EM_EMPTY: begin
        ost_r   <= mlfq_pkg::ST_LISTING;
        oid_r   <= '0;
        olvl_r  <= '0;
        oev_r   <= 1'b0;
        olast_r <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_id          = oid_r;
  assign out_level       = olvl_r;
  assign out_entry_valid = oev_r;
  assign out_last        = olast_r;

endmodule

### test/tb_mlfq_priority_table.sv
module tb_mlfq_priority_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int NUM_ROUNDS = 18;

  typedef struct packed {
    logic                        mode;
    logic [mlfq_pkg::ID_W-1:0]   proc_id;
    logic [mlfq_pkg::TIME_W-1:0] run_time;
    logic [mlfq_pkg::TIME_W-1:0] now_time;
  } sched_word_t;

  typedef struct packed {
    logic [mlfq_pkg::ST_W-1:0]  status;
    logic [mlfq_pkg::ID_W-1:0]  id;
    logic [mlfq_pkg::LVL_W-1:0] level;
    logic                       entry_valid;
    logic                       last;
  } table_word_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [mlfq_pkg::SLICE_W-1:0] cfg_wr_data;
  logic in_valid;
  logic in_stall;
  logic in_mode;
  logic [mlfq_pkg::ID_W-1:0] in_proc_id;
  logic [mlfq_pkg::TIME_W-1:0] in_run_time;
  logic [mlfq_pkg::TIME_W-1:0] in_now_time;
  logic out_valid;
  logic out_stall;
  logic [mlfq_pkg::ST_W-1:0] out_status;
  logic [mlfq_pkg::ID_W-1:0] out_id;
  logic [mlfq_pkg::LVL_W-1:0] out_level;
  logic out_entry_valid;
  logic out_last;

  mlfq_priority_table u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_proc_id     (in_proc_id),
    .in_run_time    (in_run_time),
    .in_now_time    (in_now_time),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_id         (out_id),
    .out_level      (out_level),
    .out_entry_valid(out_entry_valid),
    .out_last       (out_last)
  );

  // scheduler table shadow
  logic [mlfq_pkg::SLICE_W-1:0] sh_slice;
  logic                         sh_used  [mlfq_pkg::MAX_PROCS];
  logic [mlfq_pkg::ID_W-1:0]    sh_id    [mlfq_pkg::MAX_PROCS];
  logic [mlfq_pkg::TIME_W-1:0]  sh_run   [mlfq_pkg::MAX_PROCS];
  logic [mlfq_pkg::TIME_W-1:0]  sh_start [mlfq_pkg::MAX_PROCS];
  logic [mlfq_pkg::LVL_W-1:0]   sh_level [mlfq_pkg::MAX_PROCS];
  logic                         sh_seen  [mlfq_pkg::MAX_PROCS];

  sched_word_t pending_words[$];
  table_word_t expected_table[$];
  int  fail_count;
  int  idle_cycles;
  bit  hold_receiver;
  bit  stim_done;

  function automatic table_word_t mk_word(logic [mlfq_pkg::ST_W-1:0] st,
                                          logic [mlfq_pkg::ID_W-1:0] id,
                                          logic [mlfq_pkg::LVL_W-1:0] lvl, logic v, logic l);
    table_word_t w;
    w.status = st;
    w.id = id;
    w.level = lvl;
    w.entry_valid = v;
    w.last = l;
    return w;
  endfunction

  task automatic predict_table(input sched_word_t w);
    int free_slot;
    int final_slot;
    bit hit;
    free_slot = -1;
    final_slot = -1;
    hit = 0;
    if (w.mode == 1'b0) begin
      for (int i = 0; i < mlfq_pkg::MAX_PROCS && !hit; i++) begin
        if (sh_used[i] && sh_id[i] == w.proc_id) begin
          sh_run[i] = w.run_time;
          sh_seen[i] = 1'b1;
          expected_table.push_back(mk_word(mlfq_pkg::ST_UPDATED, w.proc_id, sh_level[i],
                                           1'b1, 1'b1));
          hit = 1;
        end else if (!sh_used[i] && free_slot < 0) begin
          free_slot = i;
        end
      end
      if (!hit) begin
        if (free_slot < 0) begin
          expected_table.push_back(mk_word(mlfq_pkg::ST_DROPPED, w.proc_id, '0, 1'b0, 1'b1));
        end else begin
          sh_used[free_slot] = 1'b1;
          sh_id[free_slot] = w.proc_id;
          sh_run[free_slot] = w.run_time;
          sh_start[free_slot] = '0;
          sh_level[free_slot] = mlfq_pkg::TOP_LEVEL;
          sh_seen[free_slot] = 1'b1;
          expected_table.push_back(mk_word(mlfq_pkg::ST_INSERTED, w.proc_id,
                                           mlfq_pkg::TOP_LEVEL, 1'b1, 1'b1));
        end
      end
    end else begin
      for (int i = 0; i < mlfq_pkg::MAX_PROCS; i++) begin
        if (sh_used[i] && !sh_seen[i]) sh_used[i] = 1'b0;
        sh_seen[i] = 1'b0;
      end
      for (int i = 0; i < mlfq_pkg::MAX_PROCS; i++) begin
        if (sh_used[i] && sh_run[i] >= sh_start[i] &&
            (sh_run[i] - sh_start[i]) >= {16'd0, sh_slice}) begin
          if (sh_level[i] != '0) sh_level[i] = sh_level[i] - 1'b1;
          sh_start[i] = sh_run[i];
        end
      end
      if (sh_slice != '0 && (w.now_time % {16'd0, sh_slice}) == 0) begin
        for (int i = 0; i < mlfq_pkg::MAX_PROCS; i++) begin
          if (sh_used[i]) sh_level[i] = mlfq_pkg::TOP_LEVEL;
        end
      end
      for (int i = 0; i < mlfq_pkg::MAX_PROCS; i++) begin
        if (sh_used[i]) final_slot = i;
      end
      if (final_slot < 0) begin
        expected_table.push_back(mk_word(mlfq_pkg::ST_LISTING, '0, '0, 1'b0, 1'b1));
      end else begin
        for (int i = 0; i < mlfq_pkg::MAX_PROCS; i++) begin
          if (sh_used[i]) begin
            expected_table.push_back(mk_word(mlfq_pkg::ST_LISTING, sh_id[i], sh_level[i],
                                             1'b1, i == final_slot));
          end
        end
      end
    end
  endtask

  function automatic sched_word_t report_word(logic [mlfq_pkg::ID_W-1:0] id,
                                              logic [mlfq_pkg::TIME_W-1:0] rt);
    sched_word_t w;
    w.mode = 1'b0;
    w.proc_id = id;
    w.run_time = rt;
    w.now_time = $urandom;
    return w;
  endfunction

  function automatic sched_word_t snapshot_word(logic [mlfq_pkg::TIME_W-1:0] now);
    sched_word_t w;
    w.mode = 1'b1;
    w.proc_id = 16'($urandom);
    w.run_time = $urandom;
    w.now_time = now;
    return w;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // driver
  int in_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid && pending_words.size() > 0) begin
        void'(pending_words.pop_front());
      end
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_words.size() > 0) begin
        in_valid <= 1'b1;
        {in_mode, in_proc_id, in_run_time, in_now_time} <= pending_words[0];
        in_gap <= gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall and monitor
  int out_gap;
  int hold_count;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap <= 0;
      hold_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_table.size() == 0) begin
          $display("%0t: unexpected word status=%0d id=%0h", $time, out_status, out_id);
          fail_count++;
        end else begin
          table_word_t exp_w;
          exp_w = expected_table.pop_front();
          if (exp_w != {out_status, out_id, out_level, out_entry_valid, out_last}) begin
            $display("%0t: mismatch expected st=%0d id=%0h lvl=%0d v=%0d l=%0d,",
                     $time, exp_w.status, exp_w.id, exp_w.level, exp_w.entry_valid,
                     exp_w.last);
            $display("  actual st=%0d id=%0h lvl=%0d v=%0d l=%0d",
                     out_status, out_id, out_level, out_entry_valid, out_last);
            fail_count++;
          end
        end
      end
      if (hold_receiver && hold_count == 0) begin
        hold_count <= 400;
        out_stall <= 1'b1;
      end else if (hold_count > 1) begin
        hold_count <= hold_count - 1;
        out_stall <= 1'b1;
      end else if (hold_count == 1) begin
        hold_count <= -1;
        out_stall <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        out_gap <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (pending_words.size() == 0 && expected_table.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_word(input sched_word_t w);
    predict_table(w);
    pending_words.push_back(w);
  endtask

  task automatic drain_all();
    wait (pending_words.size() == 0 && expected_table.size() == 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_slice(input logic [mlfq_pkg::SLICE_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sh_slice = v;
  endtask

  logic [mlfq_pkg::SLICE_W-1:0] slice_set[6] =
    '{16'd1, 16'd65535, 16'd0, 16'd7, 16'd100, 16'd3};
  logic [mlfq_pkg::ID_W-1:0] id_pool[48];

  initial begin
    sched_word_t w;
    int n;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_mode = 1'b0;
    in_proc_id = '0;
    in_run_time = '0;
    in_now_time = '0;
    out_stall = 1'b0;
    fail_count = 0;
    idle_cycles = 0;
    hold_receiver = 0;
    sh_slice = mlfq_pkg::SLICE_RESET;
    for (int i = 0; i < mlfq_pkg::MAX_PROCS; i++) begin
      sh_used[i] = 0; sh_seen[i] = 0; sh_id[i] = 0;
      sh_run[i] = 0; sh_start[i] = 0; sh_level[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed with reset slice
    queue_word(snapshot_word(32'd5));
    queue_word(report_word(16'h0000, 32'd0));
    queue_word(report_word(16'hffff, 32'hffffffff));
    queue_word(report_word(16'h0000, 32'd3));
    queue_word(report_word(16'h1234, 32'd9));
    queue_word(snapshot_word(32'd7));
    queue_word(report_word(16'h0000, 32'd20));
    queue_word(report_word(16'hffff, 32'd1));
    queue_word(snapshot_word(32'hffffffff));
    queue_word(report_word(16'h0000, 32'd25));
    queue_word(snapshot_word(32'd20));
    queue_word(snapshot_word(32'd0));
    drain_all();

    // fill table past capacity under long receiver hold
    hold_receiver = 1;
    for (int i = 0; i < mlfq_pkg::MAX_PROCS + 3; i++) begin
      queue_word(report_word(16'(16'h5500 + i), $urandom));
    end
    queue_word(snapshot_word(32'd3));
    wait (hold_count != 0);
    hold_receiver = 0;
    drain_all();

    n = 0;
    for (int r = 0; r < NUM_ROUNDS; r++) begin
      if (r % 3 == 0) write_slice(slice_set[(r / 3) % 6]);
      else if (r % 3 == 1) write_slice(16'($urandom_range(1, 40)));
      for (int i = 0; i < 48; i++) begin
        id_pool[i] = (r % 4 == 0) ? 16'($urandom) : 16'($urandom_range(0, 47));
      end
      for (int s = 0; s < 4; s++) begin
        int cnt;
        cnt = $urandom_range(0, 9);
        for (int k = 0; k < cnt; k++) begin
          if ($urandom_range(0, 9) == 0) w = report_word(16'($urandom), $urandom);
          else w = report_word(id_pool[$urandom_range(0, 47)],
                               ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 200));
          queue_word(w);
          n++;
        end
        queue_word(snapshot_word(($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 60)));
        n++;
      end
      drain_all();
    end
    for (int k = n; k < 420; k++) begin
      if ($urandom_range(0, 7) == 0) queue_word(snapshot_word($urandom_range(0, 100)));
      else queue_word(report_word(16'($urandom_range(0, 40)), $urandom_range(0, 100)));
    end
    queue_word(snapshot_word(32'd1));
    drain_all();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
